>>> design/ffha_pkg.sv
// Shared constants and types for the first-fit heap allocator.
// No dependencies.
`timescale 1ns / 1ps
package ffha_pkg;
    localparam int HEAP_BYTES   = 4096;
    localparam int MAX_SEGMENTS = 256;
    localparam int HEADER_BYTES = 8;
    localparam int NODE_BYTES   = 16;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BADSIZE = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // Per-cycle command broadcast to every cell of the free table.
    typedef struct packed {
        logic shift_up;    // take the left neighbor's entry (opens a hole)
        logic shift_down;  // take the right neighbor's entry (closes a hole)
        logic wr;          // write the selected cell
    } t_cell_cmd;
endpackage

>>> design/ffha_cell.sv
// One entry of the address-ordered free table, linked to its neighbors.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
module ffha_cell #(
    parameter int AW = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_init_valid,
    input  logic [AW-1:0]       i_init_start,
    input  logic [AW:0]         i_init_len,
    input  ffha_pkg::t_cell_cmd i_cmd,
    input  logic                i_sel,
    input  logic [AW-1:0]       i_wr_start,
    input  logic [AW:0]         i_wr_len,
    input  logic [AW-1:0]       i_left_start,
    input  logic [AW:0]         i_left_len,
    input  logic [AW-1:0]       i_right_start,
    input  logic [AW:0]         i_right_len,
    input  logic                i_up_en,
    input  logic                i_down_en,
    output logic [AW-1:0]       o_start,
    output logic [AW:0]         o_len
);
    logic [AW-1:0] r_start;
    logic [AW:0]   r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= i_init_start;
            r_len   <= i_init_valid ? i_init_len : '0;
        end else if (i_cmd.wr && i_sel) begin
            r_start <= i_wr_start;
            r_len   <= i_wr_len;
        end else if (i_cmd.shift_up && i_up_en) begin
            r_start <= i_left_start;
            r_len   <= i_left_len;
        end else if (i_cmd.shift_down && i_down_en) begin
            r_start <= i_right_start;
            r_len   <= i_right_len;
        end
    end

    assign o_start = r_start;
    assign o_len   = r_len;
endmodule

>>> design/first_fit_heap_allocator.sv
// First-fit allocator top level: free table as a chain of cells, block table
// memory and the sequencer. Depends on ffha_pkg and ffha_cell.
// Per beat: S_CHECK (and S_RD for a release), a scan over the cells one per
// cycle to find the place, S_APPLY to register the edit, S_SHIFT to apply it
// with the shift, a statistics scan over the table one entry per cycle, S_OUT;
// a rejected request skips ahead to the statistics scan. A new beat is taken only in
// S_IDLE, and S_OUT holds until the previous result has left the output register;
// a result waits there until taken. Reset (synchronous, active low) loads the
// whole heap as one segment, then clears the block table with the input not ready.
`timescale 1ns / 1ps
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES,
    parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,  // op[0]
    input  logic [23:0] s_axis_tdata,  // request_size[11:0], release_offset[23:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // status[1:0], payload_offset[13:2],
                                       // blocks_in_use[22:14], free_segments[31:23],
                                       // total_free_bytes[43:32],
                                       // largest_free_bytes[55:44],
                                       // smallest_free_bytes[67:56]
);
    localparam int AW    = $clog2(HEAP_BYTES);
    localparam int SW    = $clog2(MAX_SEGMENTS);
    localparam int CW    = SW + 1;
    localparam int SLOTS = HEAP_BYTES / 8;
    localparam int BW    = $clog2(SLOTS);
    localparam logic [AW:0] HDR  = (AW+1)'(ffha_pkg::HEADER_BYTES);
    localparam logic [AW:0] NODE = (AW+1)'(ffha_pkg::NODE_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_RD, S_APPLY, S_SHIFT, S_STAT, S_OUT
    } t_state;

    t_state        r_state;
    logic          r_op;
    logic [11:0]   r_req;
    logic [11:0]   r_rel;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic [8:0]    r_alloc;
    logic [BW-1:0] r_slot;
    logic [AW:0]   r_blen;
    logic [11:0]   r_bmem [SLOTS];
    logic [11:0]   r_bq;
    logic [AW-1:0] r_h;
    logic [1:0]    r_status;
    logic [11:0]   r_pay;
    logic          r_found;
    logic          r_shdown;
    logic          r_shup;
    logic [CW-1:0] r_hole;
    logic [AW+SW:0] r_tot;
    logic [AW:0]   r_lg;
    logic [AW:0]   r_sm;
    logic          r_ovalid;
    logic [71:0]   r_odata;

    // chain of cells
    logic [AW-1:0] w_st  [MAX_SEGMENTS];
    logic [AW:0]   w_ln  [MAX_SEGMENTS];
    ffha_pkg::t_cell_cmd w_cmd;
    logic [CW-1:0] w_wsel;
    logic [AW-1:0] w_wstart;
    logic [AW:0]   w_wlen;

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
            logic [AW-1:0] l_s, rt_s;
            logic [AW:0]   l_l, rt_l;
            if (g == 0) begin : g_l0
                assign l_s = '0;
                assign l_l = '0;
            end else begin : g_ln
                assign l_s = w_st[g-1];
                assign l_l = w_ln[g-1];
            end
            if (g == MAX_SEGMENTS - 1) begin : g_r0
                assign rt_s = '0;
                assign rt_l = '0;
            end else begin : g_rn
                assign rt_s = w_st[g+1];
                assign rt_l = w_ln[g+1];
            end
            ffha_cell #(.AW(AW)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_init_valid (g == 0),
                .i_init_start ('0),
                .i_init_len   ((AW+1)'(HEAP_BYTES)),
                .i_cmd        (w_cmd),
                .i_sel        (w_wsel == CW'(g)),
                .i_wr_start   (w_wstart),
                .i_wr_len     (w_wlen),
                .i_left_start (l_s),
                .i_left_len   (l_l),
                .i_right_start(rt_s),
                .i_right_len  (rt_l),
                .i_up_en      (CW'(g) > r_hole && CW'(g) <= r_cnt),
                .i_down_en    (CW'(g) >= r_hole && CW'(g) + 1'b1 < r_cnt),
                .o_start      (w_st[g]),
                .o_len        (w_ln[g])
            );
        end
    endgenerate

    // current scan entry and its left neighbor
    logic [AW-1:0] w_cs, w_ps;
    logic [AW:0]   w_cl, w_pl;
    logic          w_in;
    assign w_in = r_idx < r_cnt;
    assign w_cs = w_st[r_idx[SW-1:0]];
    assign w_cl = w_ln[r_idx[SW-1:0]];
    assign w_ps = w_st[r_idx[SW-1:0] - 1'b1];
    assign w_pl = w_ln[r_idx[SW-1:0] - 1'b1];

    logic [AW:0] w_need;
    assign w_need = (AW+1)'(r_req) + HDR;

    logic w_fit;
    assign w_fit = (w_cl == w_need) || ({1'b0, w_cl} >= {1'b0, w_need} + {1'b0, NODE});

    logic w_mp, w_mn;
    assign w_mp = (r_idx != '0) && ({1'b0, w_ps} + {1'b0, w_pl} == (AW+2)'(r_h));
    assign w_mn = w_in && ((AW+2)'(r_h) + (AW+2)'(r_blen) == (AW+2)'(w_cs));

    logic [AW:0] w_v;
    assign w_v = (w_cl >= NODE) ? w_cl - NODE : '0;

    logic [11:0] w_rel_h;
    assign w_rel_h = r_rel - 12'(ffha_pkg::HEADER_BYTES);

    logic [BW-1:0] w_rd_slot;
    assign w_rd_slot = BW'(w_rel_h >> 3);

    // registered edit and shift land together in the S_SHIFT cycle
    // (cells give write priority over shifting)
    logic          r_wr;
    logic [CW-1:0] r_wsel;
    logic [AW-1:0] r_wstart;
    logic [AW:0]   r_wlen;

    always_comb begin
        w_cmd    = '0;
        w_wsel   = '1;
        w_wstart = '0;
        w_wlen   = '0;
        if (r_state == S_SHIFT) begin
            w_cmd.shift_up   = r_shup;
            w_cmd.shift_down = r_shdown;
            w_cmd.wr         = r_wr;
            w_wsel           = r_wsel;
            w_wstart         = r_wstart;
            w_wlen           = r_wlen;
        end
    end

    // block table: a zero entry marks a slot with no live block
    always_ff @(posedge i_clk) begin
        r_bq <= r_bmem[w_rd_slot];
        if (r_state == S_CLEAR)
            r_bmem[r_slot] <= '0;
        else if (r_state == S_APPLY && r_op == 1'b0 && r_found
                 && r_status == ffha_pkg::ST_DONE)
            r_bmem[r_slot] <= r_req;
        else if (r_state == S_APPLY && r_op == 1'b1
                 && (w_mp || w_mn || 32'(r_cnt) < MAX_SEGMENTS))
            r_bmem[r_slot] <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_slot   <= '0;
            r_cnt    <= CW'(1);
            r_alloc  <= '0;
            r_ovalid <= 1'b0;
            r_shup   <= 1'b0;
            r_shdown <= 1'b0;
            r_wr     <= 1'b0;
        end else begin
            r_wr <= 1'b0;
            if (r_ovalid && m_axis_tready)
                r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_slot <= r_slot + 1'b1;
                    if (r_slot == BW'(SLOTS - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op     <= s_axis_tuser;
                        r_req    <= s_axis_tdata[11:0];
                        r_rel    <= s_axis_tdata[23:12];
                        r_idx    <= '0;
                        r_pay    <= '0;
                        r_found  <= 1'b0;
                        r_status <= ffha_pkg::ST_DONE;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_h    <= AW'(w_rel_h);
                    r_slot <= w_rd_slot;
                    if (r_op == 1'b0) begin
                        if (r_req == '0 || r_req[2:0] != 3'd0) begin
                            r_status <= ffha_pkg::ST_BADSIZE;
                            r_state  <= S_STAT;
                            r_idx    <= '0;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end else if (r_rel < 12'(ffha_pkg::HEADER_BYTES) || r_rel[2:0] != 3'd0
                                 || 32'(w_rel_h >> 3) >= SLOTS) begin
                        r_status <= ffha_pkg::ST_IGNORED;
                        r_state  <= S_STAT;
                        r_idx    <= '0;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_bq == '0) begin
                        r_status <= ffha_pkg::ST_IGNORED;
                        r_state  <= S_STAT;
                        r_idx    <= '0;
                    end else begin
                        r_blen  <= (AW+1)'(r_bq) + HDR;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_op == 1'b0) begin
                        if (!w_in) begin
                            r_status <= ffha_pkg::ST_NOFIT;
                            r_state  <= S_STAT;
                            r_idx    <= '0;
                        end else if (w_fit) begin
                            r_found <= 1'b1;
                            r_slot  <= BW'(w_cs >> 3);
                            r_pay   <= 12'((AW+1)'(w_cs) + HDR);
                            r_state <= S_APPLY;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else if (w_in && w_cs < r_h) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_state <= S_SHIFT;
                    r_hole  <= r_idx;
                    if (r_op == 1'b0) begin
                        r_alloc <= r_alloc + 1'b1;
                        if (w_cl == w_need) begin
                            r_shdown <= 1'b1;
                        end else begin
                            r_wr     <= 1'b1;
                            r_wsel   <= r_idx;
                            r_wstart <= w_cs + AW'(w_need);
                            r_wlen   <= w_cl - w_need;
                        end
                    end else if (w_mp && w_mn) begin
                        r_wr     <= 1'b1;
                        r_wsel   <= r_idx - 1'b1;
                        r_wstart <= w_ps;
                        r_wlen   <= w_pl + r_blen + w_cl;
                        r_shdown <= 1'b1;
                    end else if (w_mp) begin
                        r_wr     <= 1'b1;
                        r_wsel   <= r_idx - 1'b1;
                        r_wstart <= w_ps;
                        r_wlen   <= w_pl + r_blen;
                    end else if (w_mn) begin
                        r_wr     <= 1'b1;
                        r_wsel   <= r_idx;
                        r_wstart <= r_h;
                        r_wlen   <= w_cl + r_blen;
                    end else if (32'(r_cnt) >= MAX_SEGMENTS) begin
                        r_status <= ffha_pkg::ST_IGNORED;
                        r_state  <= S_STAT;
                        r_idx    <= '0;
                    end else begin
                        r_shup   <= 1'b1;
                        r_wr     <= 1'b1;
                        r_wsel   <= r_idx;
                        r_wstart <= r_h;
                        r_wlen   <= r_blen;
                    end
                    if (r_op == 1'b1 && (w_mp || w_mn || 32'(r_cnt) < MAX_SEGMENTS))
                        r_alloc <= r_alloc - 1'b1;
                end
                S_SHIFT: begin
                    if (r_shdown) r_cnt <= r_cnt - 1'b1;
                    if (r_shup)   r_cnt <= r_cnt + 1'b1;
                    r_shup   <= 1'b0;
                    r_shdown <= 1'b0;
                    r_idx    <= '0;
                    r_tot    <= '0;
                    r_lg     <= '0;
                    r_sm     <= '0;
                    r_state  <= S_STAT;
                end
                S_STAT: begin
                    if (!w_in) begin
                        r_state <= S_OUT;
                    end else begin
                        r_tot <= r_tot + (AW+SW+1)'(w_v);
                        if (r_idx == '0 || w_v > r_lg) r_lg <= w_v;
                        if (r_idx == '0 || w_v < r_sm) r_sm <= w_v;
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_idx == '0) begin
                        r_tot <= (AW+SW+1)'(w_in ? w_v : '0);
                        r_lg  <= w_in ? w_v : '0;
                        r_sm  <= w_in ? w_v : '0;
                    end
                end
                S_OUT: begin
                    // hold until the previous beat has left the output register
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {4'd0, 12'(r_sm), 12'(r_lg), 12'(r_tot),
                                     9'(r_cnt), r_alloc, r_pay, r_status};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    property p_count_range;
        @(posedge i_clk) disable iff (!i_rst_n) 32'(r_cnt) <= MAX_SEGMENTS;
    endproperty
    a_count_range: assert property (p_count_range) else $error("segment count overflow");
    a_no_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE) else $error("ready while busy");
    a_one_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_shup && r_shdown && r_state == S_SHIFT)) else $error("both shifts");
endmodule
